>>> rtl/core/i2cmts_pkg.sv
// Types, codes and defaults shared by the I2C master transfer sequencer.
package i2cmts_pkg;

   // Buffer depth default and the width of an index that can hold any depth in range
   localparam int unsigned BUFFER_DEPTH_DEF = 16;
   localparam int unsigned IDX_W            = 9;

   // Register reset values
   localparam logic [6:0] SLAVE_ADDRESS_RST    = 7'h68;
   localparam logic [7:0] REGISTER_POINTER_RST = 8'h00;
   localparam logic [3:0] TRANSFER_LENGTH_RST  = 4'd7;
   localparam logic       READ_MODE_RST        = 1'b0;

   // CSR map, one word per register
   localparam int unsigned CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CSR_SLAVE_ADDRESS    = 2'd0,
      CSR_REGISTER_POINTER = 2'd1,
      CSR_TRANSFER_LENGTH  = 2'd2,
      CSR_READ_MODE        = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FUNC_BUF_WRITE = 2'd0,
      FUNC_BUF_READ  = 2'd1,
      FUNC_BEGIN     = 2'd2,
      FUNC_STATUS    = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_START          = 4'd0,
      ST_REP_START      = 4'd1,
      ST_MT_ADDR_ACK    = 4'd2,
      ST_MT_ADDR_NACK   = 4'd3,
      ST_MT_DATA_ACK    = 4'd4,
      ST_MT_DATA_NACK   = 4'd5,
      ST_ARB_LOST       = 4'd6,
      ST_MR_ADDR_ACK    = 4'd7,
      ST_MR_ADDR_NACK   = 4'd8,
      ST_MR_DATA_ACK    = 4'd9,
      ST_MR_DATA_NACK   = 4'd10,
      ST_NO_INFO        = 4'd11,
      ST_BUS_ERROR      = 4'd12,
      ST_OTHER          = 4'd13
   } status_type;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_START     = 3'd1,
      ACT_SEND_ADDR = 3'd2,
      ACT_SEND_BYTE = 3'd3,
      ACT_ENABLE_ACK = 3'd4,
      ACT_RX_ACK    = 3'd5,
      ACT_RX_NACK   = 3'd6,
      ACT_STOP      = 3'd7
   } action_type;

endpackage

>>> rtl/core/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer: buffer, bus event decode and result register.
//
// Takes one request per clock (func in req_tuser) while its single result register is
// empty or being drained, and returns exactly one result per request from that register,
// in the cycle after acceptance. Each bus status event is answered with the next bus
// action: address byte after a start, then the register pointer and buffered bytes in a
// write transfer, or received bytes stored with ACK/NACK in a read transfer (length+1
// bytes are stored). Errors and unknown codes answer with a stop, which sets a sticky
// done flag cleared only by reset. The data buffer is a BUFFER_DEPTH x 8 memory with one
// write and one registered read per cycle in which a request is accepted; entries read
// before being written return unspecified data. Indices at or beyond BUFFER_DEPTH write
// nothing and read as zero. Configuration is written through the APB port; the user must
// write it only while idle, as the block itself does not enforce it.
module i2c_master_transfer_sequencer #(
   parameter int unsigned BUFFER_DEPTH = i2cmts_pkg::BUFFER_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // bus_status[3:0], rx_byte[11:4],
                                                         // entry_index[15:12], entry_value[23:16]
   input  logic [1:0]                        req_tuser,  // func[1:0]
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // bus_action[2:0], tx_byte[10:3],
                                                         // entry_data[18:11], done_res[19], zero
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [i2cmts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import i2cmts_pkg::*;

   localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [IDX_W-1:0] DEPTH_LIM = IDX_W'(BUFFER_DEPTH);

   // configuration registers
   logic [6:0] slave_address_ff;
   logic [7:0] register_pointer_ff;
   logic [3:0] transfer_length_ff;
   logic       read_mode_ff;
   logic       csr_wr;
   csr_index_type csr_idx;

   // sequencer state
   logic [4:0] byte_index_ff, byte_index_in;
   logic       done_ff, done_in;
   logic [7:0] buf_mem [BUFFER_DEPTH];

   // request fields
   logic       req_fire;
   func_type   func;
   status_type status;
   logic [7:0] rx_byte;
   logic [3:0] entry_index;
   logic [7:0] entry_value;

   // per-request decode
   action_type       action_in;
   logic [7:0]       tx_const_in;
   logic             tx_mem_in;
   logic             ed_mem_in;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0]       wr_data;
   logic [IDX_W-1:0] rd_idx;
   logic             stop;

   // result register
   logic       rsp_valid_ff;
   action_type rsp_action_ff;
   logic [7:0] rsp_tx_const_ff;
   logic       rsp_tx_mem_ff;
   logic       rsp_ed_mem_ff;
   logic       rsp_done_ff;
   logic       rd_ok_ff;
   logic [7:0] rd_data_ff;
   logic [7:0] mem_byte;
   logic [7:0] tx_byte_out;
   logic [7:0] entry_data_out;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff    <= SLAVE_ADDRESS_RST;
         register_pointer_ff <= REGISTER_POINTER_RST;
         transfer_length_ff  <= TRANSFER_LENGTH_RST;
         read_mode_ff        <= READ_MODE_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_SLAVE_ADDRESS:    slave_address_ff    <= csr_pwdata[6:0];
            CSR_REGISTER_POINTER: register_pointer_ff <= csr_pwdata[7:0];
            CSR_TRANSFER_LENGTH:  transfer_length_ff  <= csr_pwdata[3:0];
            CSR_READ_MODE:        read_mode_ff        <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_SLAVE_ADDRESS:    csr_prdata = {25'd0, slave_address_ff};
         CSR_REGISTER_POINTER: csr_prdata = {24'd0, register_pointer_ff};
         CSR_TRANSFER_LENGTH:  csr_prdata = {28'd0, transfer_length_ff};
         CSR_READ_MODE:        csr_prdata = {31'd0, read_mode_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // ---------------- request decode ----------------
   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign req_fire    = req_tvalid && req_tready;
   assign func        = func_type'(req_tuser);
   assign status      = status_type'(req_tdata[3:0]);
   assign rx_byte     = req_tdata[11:4];
   assign entry_index = req_tdata[15:12];
   assign entry_value = req_tdata[23:16];

   always_comb begin
      action_in     = ACT_NONE;
      tx_const_in   = 8'd0;
      tx_mem_in     = 1'b0;
      ed_mem_in     = 1'b0;
      wr_en         = 1'b0;
      wr_idx        = {5'd0, entry_index};
      wr_data       = entry_value;
      rd_idx        = {5'd0, entry_index};
      stop          = 1'b0;
      byte_index_in = byte_index_ff;
      unique case (func)
         FUNC_BUF_WRITE: wr_en = 1'b1;
         FUNC_BUF_READ:  ed_mem_in = 1'b1;
         FUNC_BEGIN:     action_in = ACT_START;
         FUNC_STATUS: begin
            rd_idx  = {4'd0, byte_index_ff};
            wr_idx  = {4'd0, byte_index_ff};
            wr_data = rx_byte;
            unique case (status)
               ST_START, ST_REP_START: begin
                  byte_index_in = 5'd0;
                  action_in     = ACT_SEND_ADDR;
                  tx_const_in   = {slave_address_ff, read_mode_ff};
               end
               ST_MT_ADDR_ACK: begin
                  action_in   = ACT_SEND_BYTE;
                  tx_const_in = register_pointer_ff;
               end
               ST_MT_DATA_ACK: begin
                  if (byte_index_ff < {1'b0, transfer_length_ff}) begin
                     action_in     = ACT_SEND_BYTE;
                     tx_mem_in     = 1'b1;
                     byte_index_in = byte_index_ff + 5'd1;
                  end else begin
                     stop = 1'b1;
                  end
               end
               ST_MR_ADDR_ACK: action_in = ACT_ENABLE_ACK;
               ST_MR_DATA_ACK: begin
                  wr_en = 1'b1;
                  if (byte_index_ff < {1'b0, transfer_length_ff}) begin
                     action_in     = ACT_RX_ACK;
                     byte_index_in = byte_index_ff + 5'd1;
                  end else begin
                     action_in = ACT_RX_NACK;
                  end
               end
               ST_NO_INFO: action_in = ACT_NONE;
               default: stop = 1'b1;
            endcase
            if (stop) action_in = ACT_STOP;
         end
         default: ;
      endcase
      done_in = done_ff || stop;
   end

   // ---------------- state and buffer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 5'd0;
         done_ff       <= 1'b0;
      end else if (req_fire) begin
         byte_index_ff <= byte_index_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && wr_en && (wr_idx < DEPTH_LIM)) begin
         buf_mem[wr_idx[AW-1:0]] <= wr_data;
      end
      if (req_fire) begin
         rd_data_ff <= buf_mem[rd_idx[AW-1:0]];
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_action_ff   <= action_in;
         rsp_tx_const_ff <= tx_const_in;
         rsp_tx_mem_ff   <= tx_mem_in;
         rsp_ed_mem_ff   <= ed_mem_in;
         rsp_done_ff     <= done_in;
         rd_ok_ff        <= rd_idx < DEPTH_LIM;
      end
   end

   assign mem_byte       = rd_ok_ff ? rd_data_ff : 8'd0;
   assign tx_byte_out    = rsp_tx_mem_ff ? mem_byte : rsp_tx_const_ff;
   assign entry_data_out = rsp_ed_mem_ff ? mem_byte : 8'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_done_ff, entry_data_out, tx_byte_out, rsp_action_ff};

   // ---------------- checks ----------------
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("done flag cleared outside reset");

   a_stop_sets_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_action_ff == ACT_STOP) |-> rsp_done_ff)
      else $error("stop returned without done flag");

   a_start_clears_index: assert property (@(posedge clock) disable iff (reset)
      (req_fire && func == FUNC_STATUS && (status == ST_START || status == ST_REP_START))
      |=> byte_index_ff == 5'd0)
      else $error("byte index not cleared after start");

   a_tx_only_on_send: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_action_ff != ACT_SEND_ADDR && rsp_action_ff != ACT_SEND_BYTE)
      |-> tx_byte_out == 8'd0)
      else $error("tx byte set on non-send action");

   a_entry_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_action_ff != ACT_NONE) |-> entry_data_out == 8'd0)
      else $error("entry data set on bus action");

endmodule

>>> tb/sv/testbench.sv
// Testbench for the I2C master transfer sequencer: directed and random request streams.
`timescale 1ns / 100ps

module testbench;
   import i2cmts_pkg::*;

   localparam int unsigned DEPTH         = BUFFER_DEPTH_DEF;
   localparam int          RANDOM_TARGET = 1100;
   localparam int          PHASE_ITEMS   = 60;
   localparam int          QUIET_LIMIT   = 1000;
   localparam int          SETTLE_CYCLES = 4;

   // status codes outside the named set, both answered with a stop
   localparam logic [3:0] ST_UNUSED_14 = 4'd14;
   localparam logic [3:0] ST_UNUSED_15 = 4'd15;

   typedef struct {
      action_type action;
      logic [7:0] tx_byte;
      logic [7:0] entry_data;
      logic       done;
   } reply_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata   = '0;  // bus_status[3:0], rx_byte[11:4],
                                             // entry_index[15:12], entry_value[23:16]
   logic [1:0]            req_tuser   = '0;  // func[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [23:0]           rsp_tdata;         // bus_action[2:0], tx_byte[10:3],
                                             // entry_data[18:11], done_res[19], zero
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // predictor state and register copies
   logic [7:0] shadow_buffer [DEPTH];
   logic [4:0] shadow_index;
   logic       shadow_done;
   logic [6:0] cfg_address;
   logic [7:0] cfg_pointer;
   logic [3:0] cfg_length;
   logic       cfg_read;

   reply_type replies_due [$];

   int error_count   = 0;
   int requests_sent = 0;
   int replies_seen  = 0;
   int stops_seen    = 0;
   int transfers_run = 0;
   int settings_used = 0;
   int rsp_hold      = 0;
   int quiet_cycles  = 0;
   bit no_idle       = 1'b0;

   i2c_master_transfer_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   // Next bus action for one request; updates the shadow state.
   function automatic reply_type sequence_event(func_type f, logic [3:0] st, logic [7:0] rx,
                                                logic [3:0] idx, logic [7:0] val);
      reply_type r;
      logic      halt;
      r.action     = ACT_NONE;
      r.tx_byte    = '0;
      r.entry_data = '0;
      halt         = 1'b0;
      case (f)
         FUNC_BUF_WRITE: shadow_buffer[idx] = val;
         FUNC_BUF_READ:  r.entry_data = shadow_buffer[idx];
         FUNC_BEGIN:     r.action = ACT_START;
         FUNC_STATUS: begin
            case (st)
               ST_START, ST_REP_START: begin
                  shadow_index = '0;
                  r.action     = ACT_SEND_ADDR;
                  r.tx_byte    = {cfg_address, cfg_read};
               end
               ST_MT_ADDR_ACK: begin
                  r.action  = ACT_SEND_BYTE;
                  r.tx_byte = cfg_pointer;
               end
               ST_MT_DATA_ACK: begin
                  if (shadow_index < cfg_length) begin
                     r.action     = ACT_SEND_BYTE;
                     r.tx_byte    = (shadow_index < DEPTH) ?
                                    shadow_buffer[shadow_index[3:0]] : 8'h00;
                     shadow_index = shadow_index + 5'd1;
                  end else begin
                     halt = 1'b1;
                  end
               end
               ST_MR_ADDR_ACK: r.action = ACT_ENABLE_ACK;
               ST_MR_DATA_ACK: begin
                  if (shadow_index < DEPTH) shadow_buffer[shadow_index[3:0]] = rx;
                  if (shadow_index < cfg_length) begin
                     r.action     = ACT_RX_ACK;
                     shadow_index = shadow_index + 5'd1;
                  end else begin
                     r.action = ACT_RX_NACK;
                  end
               end
               ST_NO_INFO: r.action = ACT_NONE;
               default:    halt = 1'b1;
            endcase
            if (halt) begin
               r.action    = ACT_STOP;
               shadow_done = 1'b1;
               stops_seen++;
            end
         end
      endcase
      r.done = shadow_done;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            replies_seen++;
            if (replies_due.size() == 0) begin
               $error("result with no request outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               want = replies_due.pop_front();
               check_field("bus_action", {5'd0, want.action}, {5'd0, rsp_tdata[2:0]});
               check_field("tx_byte", want.tx_byte, rsp_tdata[10:3]);
               check_field("entry_data", want.entry_data, rsp_tdata[18:11]);
               check_field("done_res", {7'd0, want.done}, {7'd0, rsp_tdata[19]});
               check_field("padding", 8'h00, {4'd0, rsp_tdata[23:20]});
            end
            rsp_hold = no_idle ? 0 : $urandom_range(0, 3);
         end
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("** i2c_master_transfer_sequencer: FAILED **");
         $finish;
      end
   end

   task automatic send_request(func_type f, logic [3:0] st, logic [7:0] rx,
                               logic [3:0] idx, logic [7:0] val);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {val, idx, rx, st};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      replies_due.push_back(sequence_event(f, st, rx, idx, val));
      requests_sent++;
   endtask

   task automatic bus_event(logic [3:0] st, logic [7:0] rx);
      send_request(FUNC_STATUS, st, rx, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
   endtask

   task automatic begin_transfer();
      send_request(FUNC_BEGIN, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type sel, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (sel)
         CSR_SLAVE_ADDRESS:    cfg_address = value[6:0];
         CSR_REGISTER_POINTER: cfg_pointer = value[7:0];
         CSR_TRANSFER_LENGTH:  cfg_length  = value[3:0];
         CSR_READ_MODE:        cfg_read    = value[0];
      endcase
      @(posedge clock);
   endtask

   task automatic configure(logic [6:0] address, logic [7:0] pointer, logic [3:0] length,
                            logic rd);
      wait_for_replies();
      csr_write(CSR_SLAVE_ADDRESS, {25'd0, address});
      csr_write(CSR_REGISTER_POINTER, {24'd0, pointer});
      csr_write(CSR_TRANSFER_LENGTH, {28'd0, length});
      csr_write(CSR_READ_MODE, {31'd0, rd});
      settings_used++;
   endtask

   task automatic write_transfer();
      status_type abort_codes [3] = '{ST_MT_DATA_NACK, ST_ARB_LOST, ST_BUS_ERROR};
      int         abort_at;
      transfers_run++;
      begin_transfer();
      bus_event($urandom_range(0, 1) ? ST_REP_START : ST_START, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) begin
         bus_event(ST_MT_ADDR_NACK, 8'($urandom_range(0, 255)));
         return;
      end
      bus_event(ST_MT_ADDR_ACK, 8'($urandom_range(0, 255)));
      abort_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, cfg_length) : -1;
      // length+1 data acks: the last one is answered with a stop
      for (int i = 0; i <= cfg_length; i++) begin
         if ($urandom_range(0, 19) == 0) bus_event(ST_NO_INFO, 8'($urandom_range(0, 255)));
         if (i == abort_at) begin
            bus_event(abort_codes[$urandom_range(0, 2)], 8'($urandom_range(0, 255)));
            return;
         end
         bus_event(ST_MT_DATA_ACK, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic read_transfer();
      int abort_at;
      transfers_run++;
      begin_transfer();
      bus_event($urandom_range(0, 1) ? ST_REP_START : ST_START, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) begin
         bus_event(ST_MR_ADDR_NACK, 8'($urandom_range(0, 255)));
         return;
      end
      bus_event(ST_MR_ADDR_ACK, 8'($urandom_range(0, 255)));
      abort_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, cfg_length) : -1;
      for (int i = 0; i <= cfg_length; i++) begin
         if ($urandom_range(0, 19) == 0) bus_event(ST_NO_INFO, 8'($urandom_range(0, 255)));
         if (i == abort_at) begin
            bus_event(ST_ARB_LOST, 8'($urandom_range(0, 255)));
            return;
         end
         bus_event(ST_MR_DATA_ACK, 8'($urandom_range(0, 255)));
      end
      bus_event(ST_MR_DATA_NACK, 8'($urandom_range(0, 255)));
   endtask

   task automatic buffer_traffic();
      int n;
      n = $urandom_range(1, 4);
      repeat (n)
         send_request($urandom_range(0, 1) ? FUNC_BUF_READ : FUNC_BUF_WRITE,
                      4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
   endtask

   task automatic noise_burst();
      int n;
      n = $urandom_range(1, 4);
      repeat (n)
         send_request(func_type'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)));
   endtask

   // reset register values seen in the address byte and pointer
   task automatic test_reset_defaults();
      begin_transfer();
      bus_event(ST_START, 8'h00);
      bus_event(ST_MT_ADDR_ACK, 8'hFF);
   endtask

   // full-length read: fills every buffer entry, last byte taken with NACK
   task automatic test_read_fill();
      configure(7'h7F, 8'hFF, 4'd15, 1'b1);
      begin_transfer();
      bus_event(ST_REP_START, 8'h00);
      bus_event(ST_MR_ADDR_ACK, 8'hFF);
      for (int i = 0; i < DEPTH; i++)
         bus_event(ST_MR_DATA_ACK, (i == 0) ? 8'h00 : (i == DEPTH - 1) ? 8'hFF
                                                     : 8'($urandom_range(0, 255)));
      bus_event(ST_MR_DATA_NACK, 8'h5A);
   endtask

   task automatic test_buffer_access();
      send_request(FUNC_BUF_WRITE, ST_START, 8'h00, 4'd15, 8'h00);
      send_request(FUNC_BUF_WRITE, ST_START, 8'hFF, 4'd0, 8'hFF);
      send_request(FUNC_BUF_READ, ST_OTHER, 8'h00, 4'd0, 8'h00);
      send_request(FUNC_BUF_READ, ST_OTHER, 8'hFF, 4'd15, 8'hFF);
      send_request(FUNC_BUF_READ, ST_START, 8'h00, 4'($urandom_range(1, 14)), 8'h00);
   endtask

   task automatic test_write_path();
      configure(7'h00, 8'h00, 4'd2, 1'b0);
      bus_event(ST_START, 8'h00);
      bus_event(ST_MT_ADDR_ACK, 8'h00);
      repeat (3) bus_event(ST_MT_DATA_ACK, 8'h00);
   endtask

   // every code that ends in a stop, plus the no-info code
   task automatic test_odd_statuses();
      logic [3:0] odd_codes [10] = '{ST_MT_ADDR_NACK, ST_MT_DATA_NACK, ST_ARB_LOST,
                                     ST_MR_ADDR_NACK, ST_MR_DATA_NACK, ST_NO_INFO,
                                     ST_BUS_ERROR, ST_OTHER, ST_UNUSED_14, ST_UNUSED_15};
      foreach (odd_codes[i]) bus_event(odd_codes[i], 8'($urandom_range(0, 255)));
   endtask

   task automatic test_random_phases();
      int base;
      int start;
      int phase;
      int pick;
      base  = requests_sent;
      phase = 0;
      while (requests_sent - base < RANDOM_TARGET) begin
         case (phase)
            0:       configure(7'h00, 8'h00, 4'd0, 1'b0);
            1:       configure(7'h7F, 8'hFF, 4'd15, 1'b1);
            2:       configure(7'h7F, 8'h00, 4'd15, 1'b0);
            3:       configure(7'h00, 8'hFF, 4'd0, 1'b1);
            default: configure(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                               4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
         endcase
         no_idle = (phase % 4 == 2);
         start   = requests_sent;
         while (requests_sent - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               if (cfg_read) read_transfer(); else write_transfer();
            end else if (pick == 6) begin
               if (cfg_read) write_transfer(); else read_transfer();
            end else if (pick == 7) begin
               buffer_traffic();
            end else begin
               noise_burst();
            end
         end
         phase++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      shadow_index = '0;
      shadow_done  = 1'b0;
      cfg_address  = SLAVE_ADDRESS_RST;
      cfg_pointer  = REGISTER_POINTER_RST;
      cfg_length   = TRANSFER_LENGTH_RST;
      cfg_read     = READ_MODE_RST;
      foreach (shadow_buffer[i]) shadow_buffer[i] = 8'h00;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_read_fill();
      test_buffer_access();
      test_write_path();
      test_odd_statuses();
      test_random_phases();

      wait_for_replies();
      $display("%0d requests, %0d results checked, %0d transfers, %0d stops",
               requests_sent, replies_seen, transfers_run, stops_seen);
      $display("%0d register settings incl. extremes; all status codes, buffer ops, stalls",
               settings_used);
      if (error_count == 0)
         $display("** i2c_master_transfer_sequencer: PASSED **");
      else
         $display("** i2c_master_transfer_sequencer: FAILED **");
      $finish;
   end

endmodule

>>> i2c_master_transfer_sequencer.f
rtl/core/i2cmts_pkg.sv
rtl/core/i2c_master_transfer_sequencer.sv
tb/sv/testbench.sv
